// ----- src/fmpd_pkg.sv -----
// shared constants, angle table and state type for the fm phase discriminator
package fmpd_pkg;

	// binary angle accumulator: one full turn is 2^32
	localparam int ANGLE_BITS = 32;
	// guard bits appended below the sample lsb
	localparam int GUARD_BITS = 16;
	// width of the frequency result
	localparam int OUT_BITS = 16;
	// depth and index width of the arctangent table
	localparam int ATAN_DEPTH = 32;
	localparam int ATAN_IDX_BITS = 5;

	localparam logic [ANGLE_BITS-1:0] HALF_TURN = 32'h8000_0000;

	// atan(2^-k) as a fraction of a turn, scaled by 2^32 and rounded
	localparam logic [ANGLE_BITS-1:0] ATAN_TURNS [ATAN_DEPTH] = '{
		32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
		32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
		32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
		32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
		32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
		32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051,
		32'h0000_0029, 32'h0000_0014, 32'h0000_000A, 32'h0000_0005,
		32'h0000_0003, 32'h0000_0001, 32'h0000_0001, 32'h0000_0000
	};

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FINISH
	} fmpd_state_t;

endpackage

// ----- src/fmpd_serial_addsub.sv -----
// one-bit serial adder/subtractor with a carry flop, lsb first
module fmpd_serial_addsub (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic first,
	input  logic sub,
	input  logic a,
	input  logic b,
	output logic s
);

	logic carry_q;
	logic bb;
	logic cin;

	// subtract as a + ~b + 1, the +1 enters as the first carry
	assign bb  = b ^ sub;
	assign cin = first ? sub : carry_q;
	assign s   = a ^ bb ^ cin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carry_q <= 1'b0;
		end else if (en) begin
			carry_q <= (a & bb) | (a & cin) | (bb & cin);
		end
	end

endmodule

// ----- src/fmpd_cordic.sv -----
// bit-serial vectoring cordic: x and y circulate through shift registers lsb first
module fmpd_cordic #(
	parameter int SAMPLE_BITS  = 16,
	parameter int CORDIC_STEPS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic [SAMPLE_BITS+fmpd_pkg::GUARD_BITS+1:0] x_init,
	input  logic [SAMPLE_BITS+fmpd_pkg::GUARD_BITS+1:0] y_init,
	input  logic [fmpd_pkg::ANGLE_BITS-1:0]       ang_init,
	output logic                                  done,
	output logic [fmpd_pkg::ANGLE_BITS-1:0]       ang
);

	// two bits of headroom cover the cordic gain on a full-scale vector
	localparam int XW = SAMPLE_BITS + fmpd_pkg::GUARD_BITS + 2;
	localparam int BW = $clog2(XW);
	localparam int SW = $clog2(CORDIC_STEPS);
	localparam int CW = ((BW > SW) ? BW : SW) + 1;

	logic [XW-1:0]                   x_q;
	logic [XW-1:0]                   y_q;
	logic                            xs_q;
	logic                            ys_q;
	logic [fmpd_pkg::ANGLE_BITS-1:0] ang_q;
	logic [BW-1:0]                   bit_q;
	logic [SW-1:0]                   step_q;
	logic                            busy_q;
	logic                            done_q;

	logic                            first;
	logic                            sign_x;
	logic                            sign_y;
	logic [CW-1:0]                   bit_pos;
	logic                            over;
	logic [BW-1:0]                   idx;
	logic                            tap_x;
	logic                            tap_y;
	logic                            x_bit;
	logic                            y_bit;
	logic                            last_bit;
	logic                            last_step;
	logic [fmpd_pkg::ANGLE_BITS-1:0] turn;

	assign first  = (bit_q == '0);
	// top bits already hold new results after the first bit, so keep the old signs
	assign sign_x = first ? x_q[XW-1] : xs_q;
	assign sign_y = first ? y_q[XW-1] : ys_q;

	// old bit (bit + step) sits at position step; beyond the msb it is the sign
	assign bit_pos = CW'(bit_q) + CW'(step_q);
	assign over    = (bit_pos > CW'(XW - 1));
	assign idx     = over ? '0 : BW'(step_q);
	assign tap_x   = over ? sign_x : x_q[idx];
	assign tap_y   = over ? sign_y : y_q[idx];

	assign last_bit  = (bit_q == BW'(XW - 1));
	assign last_step = (step_q == SW'(CORDIC_STEPS - 1));
	assign turn      = fmpd_pkg::ATAN_TURNS[fmpd_pkg::ATAN_IDX_BITS'(step_q)];

	// y < 0: x -= y>>k, y += x>>k; otherwise the reverse
	fmpd_serial_addsub u_x_add (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (busy_q),
		.first (first),
		.sub   (sign_y),
		.a     (x_q[0]),
		.b     (tap_y),
		.s     (x_bit)
	);

	fmpd_serial_addsub u_y_add (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (busy_q),
		.first (first),
		.sub   (~sign_y),
		.a     (y_q[0]),
		.b     (tap_x),
		.s     (y_bit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			bit_q  <= '0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				bit_q  <= '0;
				step_q <= '0;
			end else if (busy_q) begin
				if (last_bit) begin
					bit_q <= '0;
					if (last_step) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end else begin
						step_q <= SW'(step_q + 1'b1);
					end
				end else begin
					bit_q <= BW'(bit_q + 1'b1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= x_init;
			y_q   <= y_init;
			ang_q <= ang_init;
		end else if (busy_q) begin
			x_q <= {x_bit, x_q[XW-1:1]};
			y_q <= {y_bit, y_q[XW-1:1]};
			if (first) begin
				xs_q <= x_q[XW-1];
				ys_q <= y_q[XW-1];
			end
			if (last_bit) begin
				ang_q <= sign_y ? (ang_q - turn) : (ang_q + turn);
			end
		end
	end

	assign done = done_q;
	assign ang  = ang_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("cordic started while busy");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (!busy_q && $past(busy_q)))
		else $error("cordic done without a finished run");

	a_bit_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (bit_q <= BW'(XW - 1)))
		else $error("cordic bit counter out of range");

endmodule

// ----- src/fm_phase_discriminator.sv -----
// top level: fm quadrature discriminator, atan2 phase by bit-serial cordic
//
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  input   | in_valid, in_stall, i_sample, q_sample   | sample in
//  output  | out_valid, out_stall, freq_out           | freq out
//
// - the cordic moves one bit of x and y per cycle in each of its steps
// - reset clears the previous phase to zero and empties the output register
// - in_stall is high from a transfer until the result is written to the output register
// - the output register holds a result while out_stall is high; the cordic keeps
//   working on the next sample meanwhile and waits at the end only if still full
module fm_phase_discriminator #(
	parameter int SAMPLE_BITS  = 16,
	parameter int PHASE_BITS   = 16,
	parameter int CORDIC_STEPS = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic signed [SAMPLE_BITS-1:0]          i_sample,
	input  logic signed [SAMPLE_BITS-1:0]          q_sample,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [fmpd_pkg::OUT_BITS-1:0]   freq_out
);

	localparam int XW = SAMPLE_BITS + fmpd_pkg::GUARD_BITS + 2;
	localparam int AB = fmpd_pkg::ANGLE_BITS;
	localparam int OB = fmpd_pkg::OUT_BITS;

	fmpd_pkg::fmpd_state_t state_q;
	fmpd_pkg::fmpd_state_t state_d;

	logic              in_xfer;
	logic              out_free;
	logic              out_load;
	logic              zero_q;
	logic              in_zero;
	logic              in_neg;
	logic [XW-1:0]     x_ext;
	logic [XW-1:0]     y_ext;
	logic [XW-1:0]     x_init;
	logic [XW-1:0]     y_init;
	logic [AB-1:0]     ang_init;
	logic              cordic_done;
	logic [AB-1:0]     cordic_ang;
	logic [PHASE_BITS-1:0] phase;
	logic [PHASE_BITS-1:0] diff;
	logic [OB-1:0]     freq;
	logic [PHASE_BITS-1:0] prev_phase_q;
	logic              out_valid_q;
	logic [OB-1:0]     freq_q;

	// handshake
	assign in_stall = (state_q != fmpd_pkg::ST_IDLE);
	assign in_xfer  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign out_load = (state_q == fmpd_pkg::ST_FINISH) && out_free;

	// samples get guard bits below and headroom above
	assign x_ext = {{2{i_sample[SAMPLE_BITS-1]}}, i_sample, {fmpd_pkg::GUARD_BITS{1'b0}}};
	assign y_ext = {{2{q_sample[SAMPLE_BITS-1]}}, q_sample, {fmpd_pkg::GUARD_BITS{1'b0}}};

	// left half plane: turn by half a turn before the cordic steps
	assign in_neg   = i_sample[SAMPLE_BITS-1];
	assign in_zero  = (i_sample == '0) && (q_sample == '0);
	assign x_init   = in_neg ? (XW'(0) - x_ext) : x_ext;
	assign y_init   = in_neg ? (XW'(0) - y_ext) : y_ext;
	assign ang_init = in_neg ? fmpd_pkg::HALF_TURN : '0;

	fmpd_cordic #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (in_xfer),
		.x_init  (x_init),
		.y_init  (y_init),
		.ang_init(ang_init),
		.done    (cordic_done),
		.ang     (cordic_ang)
	);

	// round the 32-bit angle half-up to the phase width, wrapping mod one turn
	generate
		if (PHASE_BITS >= AB) begin : g_phase_full
			assign phase = PHASE_BITS'(cordic_ang);
		end else begin : g_phase_round
			localparam int SH = AB - PHASE_BITS;
			logic [AB-1:0] rounded;
			assign rounded = cordic_ang + (AB'(1) << (SH - 1));
			assign phase   = rounded[AB-1:SH];
		end
	endgenerate

	// the zero vector has phase zero
	assign diff = (zero_q ? '0 : phase) - prev_phase_q;

	// half a turn maps to the msb of the result
	generate
		if (PHASE_BITS >= OB) begin : g_freq_trunc
			assign freq = diff[PHASE_BITS-1 -: OB];
		end else begin : g_freq_fill
			assign freq = {diff, {(OB - PHASE_BITS){1'b0}}};
		end
	endgenerate

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fmpd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			fmpd_pkg::ST_IDLE: begin
				if (in_xfer) begin
					state_d = fmpd_pkg::ST_RUN;
				end
			end
			fmpd_pkg::ST_RUN: begin
				if (cordic_done) begin
					state_d = fmpd_pkg::ST_FINISH;
				end
			end
			fmpd_pkg::ST_FINISH: begin
				if (out_free) begin
					state_d = fmpd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = fmpd_pkg::ST_IDLE;
			end
		endcase
	end

	// phase memory and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_phase_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_load) begin
				prev_phase_q <= zero_q ? '0 : phase;
				out_valid_q  <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			zero_q <= in_zero;
		end
		if (out_load) begin
			freq_q <= freq;
		end
	end

	assign out_valid = out_valid_q;
	assign freq_out  = freq_q;

	a_xfer_starts_run: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> (state_q == fmpd_pkg::ST_RUN))
		else $error("transfer did not start a cordic run");

	a_done_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		cordic_done |-> (state_q == fmpd_pkg::ST_RUN))
		else $error("cordic finished outside a run");

	a_prev_only_on_load: assert property (@(posedge clk) disable iff (!arst_n)
		!out_load |=> $stable(prev_phase_q))
		else $error("previous phase changed without a result");

	a_valid_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == fmpd_pkg::ST_FINISH))
		else $error("output became valid outside finish");

endmodule

// ----- dv/fm_phase_discriminator_tb.sv -----
// self-checking testbench for the fm phase discriminator: directed and random iq streams
module fm_phase_discriminator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// block configuration, kept equal to the defaults of the design
	localparam int SAMPLE_BITS  = 16;
	localparam int PHASE_BITS   = 16;
	localparam int CORDIC_STEPS = 16;
	localparam int FREQ_BITS    = fmpd_pkg::OUT_BITS;

	// cycles the block spends on one sample, used for the tail wait
	localparam int ITEM_CYCLES = CORDIC_STEPS * (SAMPLE_BITS + 18) + 3;
	// cycles with no transfer on either side before the run is declared hung
	localparam int HANG_LIMIT = 20 * ITEM_CYCLES + 10000;

	localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
	localparam real FULL_SCALE = 2.0 ** (SAMPLE_BITS - 1) - 1.0;
	localparam real TWO_PI = 6.283185307179586;

	// atan(2^-k) in turns, one turn = 2^32
	localparam logic [31:0] ARCTAN_STEP_ANGLE [32] = '{
		32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
		32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
		32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
		32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
		32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
		32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051,
		32'h0000_0029, 32'h0000_0014, 32'h0000_000A, 32'h0000_0005,
		32'h0000_0003, 32'h0000_0001, 32'h0000_0001, 32'h0000_0000
	};

	logic                          clk;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_stall;
	logic signed [SAMPLE_BITS-1:0] i_sample;
	logic signed [SAMPLE_BITS-1:0] q_sample;
	logic                          out_valid;
	logic                          out_stall;
	logic signed [FREQ_BITS-1:0]   freq_out;

	// frequency values predicted for accepted samples, oldest first
	logic [FREQ_BITS-1:0] pending_freq [$];
	// phase of the previous accepted sample, starts at zero like the block after reset
	logic [PHASE_BITS-1:0] model_phase = '0;
	int mismatch_count = 0;
	int idle_cycles = 0;
	// when set the sender drives back-to-back transfers
	bit sender_quiet = 1'b0;

	fm_phase_discriminator #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.PHASE_BITS  (PHASE_BITS),
		.CORDIC_STEPS(CORDIC_STEPS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.i_sample (i_sample),
		.q_sample (q_sample),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.freq_out (freq_out)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// ---------------------------------------------------------------
	// prediction
	// ---------------------------------------------------------------

	// binary-angle phase of one sample by vectoring cordic
	function automatic logic [PHASE_BITS-1:0] sample_phase(
		input logic signed [SAMPLE_BITS-1:0] i_in,
		input logic signed [SAMPLE_BITS-1:0] q_in
	);
		longint x;
		longint y;
		longint nx;
		longint ny;
		logic [31:0] acc;
		int sh;
		// atan2 of the origin is taken as zero
		if (i_in == 0 && q_in == 0)
			return '0;
		x = longint'(i_in) * 65536;
		y = longint'(q_in) * 65536;
		acc = '0;
		// left half plane: turn by half a turn first
		if (x < 0) begin
			x = -x;
			y = -y;
			acc = 32'h8000_0000;
		end
		for (int k = 0; k < CORDIC_STEPS && k < 32; k++) begin
			if (y < 0) begin
				nx = x - (y >>> k);
				ny = y + (x >>> k);
				acc = acc - ARCTAN_STEP_ANGLE[k];
			end else begin
				nx = x + (y >>> k);
				ny = y - (x >>> k);
				acc = acc + ARCTAN_STEP_ANGLE[k];
			end
			x = nx;
			y = ny;
		end
		if (PHASE_BITS >= 32)
			return acc[PHASE_BITS-1:0];
		// round half up to the phase width, wraps modulo one turn
		sh = 32 - PHASE_BITS;
		acc = acc + (32'd1 << (sh - 1));
		return PHASE_BITS'(acc >> sh);
	endfunction

	// phase step scaled so that half a turn is the most negative code
	function automatic logic [FREQ_BITS-1:0] step_to_freq(input logic [PHASE_BITS-1:0] step);
		logic [31:0] wide;
		wide = 32'(step);
		if (PHASE_BITS >= 16)
			wide = wide >> (PHASE_BITS - 16);
		else
			wide = wide << (16 - PHASE_BITS);
		return wide[FREQ_BITS-1:0];
	endfunction

	// update the phase memory and queue the expected frequency
	task automatic predict_freq(
		input logic signed [SAMPLE_BITS-1:0] i_in,
		input logic signed [SAMPLE_BITS-1:0] q_in
	);
		logic [PHASE_BITS-1:0] phase;
		phase = sample_phase(i_in, q_in);
		// modular subtraction does the wrap into +-half a turn
		pending_freq.push_back(step_to_freq(phase - model_phase));
		model_phase = phase;
	endtask

	// ---------------------------------------------------------------
	// idling helpers
	// ---------------------------------------------------------------

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 60)
			return 0;
		if (r < 85)
			return $urandom_range(3, 1);
		if (r < 97)
			return $urandom_range(40, 4);
		return $urandom_range(700, 100);
	endfunction

	// round and clamp a real value to a sample code
	function automatic logic signed [SAMPLE_BITS-1:0] to_sample(input real v);
		int r;
		r = $rtoi(v >= 0.0 ? v + 0.5 : v - 0.5);
		if (r > int'(SAMPLE_MAX))
			r = int'(SAMPLE_MAX);
		if (r < int'(SAMPLE_MIN))
			r = int'(SAMPLE_MIN);
		return r[SAMPLE_BITS-1:0];
	endfunction

	// ---------------------------------------------------------------
	// sender
	// ---------------------------------------------------------------

	// one sample transfer; valid stays high on return so a following send can go back to back
	task automatic send_sample(
		input logic signed [SAMPLE_BITS-1:0] i_in,
		input logic signed [SAMPLE_BITS-1:0] q_in
	);
		int gap;
		gap = sender_quiet ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		i_sample <= i_in;
		q_sample <= q_in;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		predict_freq(i_in, q_in);
	endtask

	// drop valid and hold off until every predicted result has been seen
	task automatic wait_for_results();
		in_valid <= 1'b0;
		while (pending_freq.size() != 0)
			@(posedge clk);
	endtask

	// ---------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------

	// axes, corners and the smallest nonzero vectors
	task automatic test_axes_and_corners();
		send_sample(SAMPLE_MAX, 0);
		send_sample(0, SAMPLE_MAX);
		send_sample(SAMPLE_MIN, 0);
		send_sample(0, SAMPLE_MIN);
		send_sample(SAMPLE_MAX, SAMPLE_MAX);
		send_sample(SAMPLE_MIN, SAMPLE_MIN);
		send_sample(SAMPLE_MIN, SAMPLE_MAX);
		send_sample(SAMPLE_MAX, SAMPLE_MIN);
		send_sample(1, 0);
		send_sample(0, 1);
		send_sample(-1, 0);
		send_sample(0, -1);
		send_sample(1, 1);
		send_sample(-1, -1);
	endtask

	// origin sample reads as phase zero, also twice in a row
	task automatic test_zero_sample();
		send_sample(SAMPLE_MIN, SAMPLE_MAX);
		send_sample(0, 0);
		send_sample(0, 0);
	endtask

	// positive then negative real axis gives exactly half a turn both ways
	task automatic test_half_turn();
		send_sample(100, 0);
		send_sample(-100, 0);
		send_sample(100, 0);
		send_sample(SAMPLE_MIN, 0);
	endtask

	// sender stops after each transfer until the block has drained
	task automatic test_drained_pauses();
		for (int n = 0; n < 6; n++) begin
			send_sample(SAMPLE_BITS'($urandom), SAMPLE_BITS'($urandom));
			wait_for_results();
		end
	endtask

	// bursts of fm phasors with random deviation, mixed with noise bursts
	task automatic test_random_streams(input int count);
		int sent;
		int burst;
		int kind;
		int r;
		logic [15:0] carrier;
		logic [15:0] rate;
		real amp;
		real a;
		sent = 0;
		while (sent < count) begin
			burst = $urandom_range(60, 1);
			kind = $urandom_range(99);
			sender_quiet = ($urandom_range(99) < 15);
			r = $urandom_range(99);
			if (r < 40)
				amp = FULL_SCALE;
			else if (r < 80)
				amp = real'($urandom_range(32767, 1));
			else
				amp = real'($urandom_range(64, 1));
			carrier = 16'($urandom);
			case ($urandom_range(3))
				0: rate = 16'($signed(9'($urandom)));
				1: rate = 16'($urandom);
				// steps around half a turn hit the wrap point
				2: rate = 16'h8000 + 16'($signed(4'($urandom)));
				default: rate = '0;
			endcase
			for (int n = 0; n < burst && sent < count; n++) begin
				if (kind < 75) begin
					a = TWO_PI * real'(carrier) / 65536.0;
					send_sample(to_sample(amp * $cos(a)), to_sample(amp * $sin(a)));
					carrier = carrier + rate;
				end else if (kind < 90) begin
					send_sample(SAMPLE_BITS'($urandom), SAMPLE_BITS'($urandom));
				end else begin
					// tiny vectors, origin and axes included
					send_sample(SAMPLE_BITS'(int'($urandom_range(8)) - 4),
						SAMPLE_BITS'(int'($urandom_range(8)) - 4));
				end
				sent++;
			end
		end
		sender_quiet = 1'b0;
	endtask

	// ---------------------------------------------------------------
	// receiver stall, checker and hang watchdog
	// ---------------------------------------------------------------

	// random stall pattern with occasional long stall-free stretches
	initial begin
		forever begin
			if ($urandom_range(99) < 4) begin
				out_stall <= 1'b0;
				repeat (3000) @(posedge clk);
			end else begin
				out_stall <= 1'b0;
				repeat (pick_gap() + 1) @(posedge clk);
				out_stall <= 1'b1;
				repeat (pick_gap() + 1) @(posedge clk);
			end
		end
	end

	// compare each output transfer with the oldest prediction
	always @(posedge clk) begin
		if (out_valid === 1'b1 && out_stall === 1'b0) begin
			if (pending_freq.size() == 0) begin
				$display("%0t: freq_out transfer %0d with no sample pending", $time, freq_out);
				mismatch_count++;
			end else begin
				if (freq_out !== pending_freq[0]) begin
					$display("%0t: freq_out expected %0d actual %0d", $time,
						$signed(pending_freq[0]), freq_out);
					mismatch_count++;
				end
				void'(pending_freq.pop_front());
			end
		end
	end

	// count cycles with no transfer on either channel
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= HANG_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------
	// sequence
	// ---------------------------------------------------------------

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		i_sample <= '0;
		q_sample <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_axes_and_corners();
		test_zero_sample();
		test_half_turn();
		test_drained_pauses();
		test_random_streams(1120);

		// drain, then keep the clock running so that any stray transfer shows
		wait_for_results();
		repeat (ITEM_CYCLES + 50) @(posedge clk);

		if (mismatch_count == 0 && pending_freq.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
